>>> sv/c2p_pkg.sv
// Shared types, constants and tables of the Cartesian-to-polar converter.
`timescale 1ns / 1ps
`default_nettype none
package c2p_pkg;

  // Default number of rotation cells, and the limits of the table below.
  localparam int C2P_STAGES     = 16;
  localparam int C2P_MAX_STAGES = 24;

  // Input and output widths.
  localparam int C2P_IN_W    = 16;
  localparam int C2P_GUARD_W = 8;
  // Datapath x and y: sign, one growth bit for the negated corner, gain growth.
  localparam int C2P_XY_W    = 27;
  // Angle accumulator, Q.24 radians, room for pi plus the table sum.
  localparam int C2P_Z_W     = 28;
  localparam int C2P_GAIN_W  = 24;
  localparam int C2P_MAGX_W  = 26;
  localparam int C2P_PROD_W  = C2P_MAGX_W + C2P_GAIN_W;

  localparam logic signed [C2P_Z_W-1:0] C2P_ANG_PI = C2P_Z_W'(52707179);
  localparam logic [15:0] C2P_MAG_MAX   = 16'd46341;
  localparam logic signed [15:0] C2P_PHASE_MAX = 16'sd25736;

  // round(atan(2^-i) * 2^24)
  localparam logic [C2P_Z_W-1:0] C2P_ATAN [C2P_MAX_STAGES] = '{
    28'd13176795, 28'd7778716, 28'd4110060, 28'd2086331, 28'd1047214, 28'd524117,
    28'd262123, 28'd131069, 28'd65536, 28'd32768, 28'd16384, 28'd8192,
    28'd4096, 28'd2048, 28'd1024, 28'd512, 28'd256, 28'd128,
    28'd64, 28'd32, 28'd16, 28'd8, 28'd4, 28'd2
  };

  // round(2^24 / K) for stage counts 8 to 24.
  localparam logic [C2P_GAIN_W-1:0] C2P_INV_GAIN [17] = '{
    24'd10188117, 24'd10188040, 24'd10188020, 24'd10188015, 24'd10188014,
    24'd10188014, 24'd10188014, 24'd10188014, 24'd10188014, 24'd10188014,
    24'd10188014, 24'd10188014, 24'd10188014, 24'd10188014, 24'd10188014,
    24'd10188014, 24'd10188014
  };

  // Number of rotation cells actually built for a given stage setting.
  function automatic int c2p_stage_count(int stages);
    int n;
    n = stages;
    if (n > C2P_MAX_STAGES) n = C2P_MAX_STAGES;
    if (n < 1) n = 1;
    return n;
  endfunction

  // Gain correction for a stage setting, nearest table entry outside 8..24.
  function automatic logic [C2P_GAIN_W-1:0] c2p_inv_gain(int stages);
    int gi;
    gi = stages - 8;
    if (gi < 0) gi = 0;
    if (gi > 16) gi = 16;
    return C2P_INV_GAIN[gi];
  endfunction

  // Vector handed from cell to cell.
  typedef struct packed {
    logic                      vld;
    logic                      zero;
    logic signed [C2P_XY_W-1:0] x;
    logic signed [C2P_XY_W-1:0] y;
    logic signed [C2P_Z_W-1:0]  z;
  } c2p_vec_t;

endpackage
`default_nettype wire

>>> sv/c2p_pre.sv
// Input conditioning: folds the left half-plane over and scales up by the guard bits.
`timescale 1ns / 1ps
`default_nettype none
module c2p_pre import c2p_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       req_i,
  input  wire logic signed [C2P_IN_W-1:0] real_in_i,
  input  wire logic signed [C2P_IN_W-1:0] imag_in_i,
  output c2p_vec_t                        vec_o
);

  logic                       vld_q;
  c2p_vec_t                   pay_d, pay_q;
  logic signed [C2P_IN_W:0]   xe, ye;

  always_comb begin
    xe = {real_in_i[C2P_IN_W-1], real_in_i};
    ye = {imag_in_i[C2P_IN_W-1], imag_in_i};
    pay_d      = '0;
    pay_d.zero = (real_in_i == '0) && (imag_in_i == '0);
    pay_d.z    = '0;
    // A vector in the left half-plane is negated and starts from plus or minus pi.
    if (real_in_i[C2P_IN_W-1]) begin
      xe      = -xe;
      ye      = -ye;
      pay_d.z = imag_in_i[C2P_IN_W-1] ? -C2P_ANG_PI : C2P_ANG_PI;
    end
    pay_d.x = {{(C2P_XY_W-C2P_IN_W-1-C2P_GUARD_W){xe[C2P_IN_W]}}, xe, {C2P_GUARD_W{1'b0}}};
    pay_d.y = {{(C2P_XY_W-C2P_IN_W-1-C2P_GUARD_W){ye[C2P_IN_W]}}, ye, {C2P_GUARD_W{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= req_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  always_comb begin
    vec_o     = pay_q;
    vec_o.vld = vld_q;
  end

endmodule
`default_nettype wire

>>> sv/c2p_cell.sv
// One vectoring rotation cell of the chain, with its fixed shift and angle.
`timescale 1ns / 1ps
`default_nettype none
module c2p_cell import c2p_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire c2p_vec_t vec_i,
  output c2p_vec_t      vec_o
);

  localparam logic signed [C2P_Z_W-1:0] Atan = C2P_ATAN[IDX];

  logic                        vld_q;
  c2p_vec_t                    pay_d, pay_q;
  logic signed [C2P_XY_W-1:0]  dx, dy;

  always_comb begin
    dx    = vec_i.y >>> IDX;
    dy    = vec_i.x >>> IDX;
    pay_d = vec_i;
    // Rotate toward the real axis: the sign of y picks the direction.
    if (!vec_i.y[C2P_XY_W-1]) begin
      pay_d.x = vec_i.x + dx;
      pay_d.y = vec_i.y - dy;
      pay_d.z = vec_i.z + Atan;
    end else begin
      pay_d.x = vec_i.x - dx;
      pay_d.y = vec_i.y + dy;
      pay_d.z = vec_i.z - Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vec_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  always_comb begin
    vec_o     = pay_q;
    vec_o.vld = vld_q;
  end

endmodule
`default_nettype wire

>>> sv/c2p_post.sv
// Output stages: gain correction, rounding and saturation of magnitude and phase.
`timescale 1ns / 1ps
`default_nettype none
module c2p_post import c2p_pkg::*; #(
  parameter int STAGES = C2P_STAGES
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire c2p_vec_t     vec_i,
  output logic              done_o,
  output logic [15:0]       magnitude_o,
  output logic signed [15:0] phase_o
);

  localparam logic [C2P_GAIN_W-1:0] InvGain = c2p_inv_gain(STAGES);
  localparam int PhW = C2P_Z_W + 1 - 11;

  logic                      vld_q, done_q;
  logic [C2P_MAGX_W-1:0]     xm;
  logic [C2P_PROD_W-1:0]     prod_d, prod_q;
  logic signed [C2P_Z_W:0]   zr;
  logic signed [PhW-1:0]     ph;
  logic signed [15:0]        phase_d, phase_q, phase_out_q;
  logic                      zero_q;
  logic [C2P_PROD_W:0]       mr;
  logic [C2P_PROD_W-32:0]    mag_full;
  logic [15:0]               mag_d, mag_q;

  // First stage: multiply by the gain correction, round and clamp the angle.
  always_comb begin
    xm     = vec_i.x[C2P_XY_W-1] ? '0 : vec_i.x[C2P_MAGX_W-1:0];
    prod_d = C2P_PROD_W'(xm) * C2P_PROD_W'(InvGain);
    zr     = {vec_i.z[C2P_Z_W-1], vec_i.z} + (C2P_Z_W+1)'(1024);
    ph     = PhW'(zr >>> 11);
    if (ph > PhW'(C2P_PHASE_MAX)) begin
      phase_d = C2P_PHASE_MAX;
    end else if (ph < -PhW'(C2P_PHASE_MAX)) begin
      phase_d = -C2P_PHASE_MAX;
    end else begin
      phase_d = ph[15:0];
    end
  end

  // Second stage: round and saturate the magnitude; zero input forces zeros.
  always_comb begin
    mr       = {1'b0, prod_q} + (C2P_PROD_W+1)'(64'd2147483648);
    mag_full = mr[C2P_PROD_W:32];
    if (mag_full > (C2P_PROD_W-31)'(C2P_MAG_MAX)) begin
      mag_d = C2P_MAG_MAX;
    end else begin
      mag_d = mag_full[15:0];
    end
    if (zero_q) begin
      mag_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= vec_i.vld;
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q      <= prod_d;
    phase_q     <= phase_d;
    zero_q      <= vec_i.zero;
    mag_q       <= mag_d;
    phase_out_q <= zero_q ? '0 : phase_q;
  end

  assign done_o      = done_q;
  assign magnitude_o = mag_q;
  assign phase_o     = phase_out_q;

endmodule
`default_nettype wire

>>> sv/cartesian_to_polar.sv
// Top level of the Cartesian-to-polar converter: input stage, rotation chain, output stages.
// A new sample may be started in every clock cycle; busy_o never rises. Each sample's
// magnitude and phase appear with done_o after passing through one input stage, one register
// per rotation cell of the chain, and two output stages for the gain multiply and the
// rounding. The receiver cannot stall the results.
`timescale 1ns / 1ps
`default_nettype none
module cartesian_to_polar import c2p_pkg::*; #(
  parameter int STAGES = C2P_STAGES
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic signed [15:0]   real_in_i,
  input  wire logic signed [15:0]   imag_in_i,
  output logic                      done_o,
  output logic [15:0]               magnitude_o,
  output logic signed [15:0]        phase_o
);

  localparam int NCells = c2p_stage_count(STAGES);

  c2p_vec_t chain [NCells+1];

  assign busy_o = 1'b0;

  c2p_pre u_pre (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (start_i),
    .real_in_i (real_in_i),
    .imag_in_i (imag_in_i),
    .vec_o     (chain[0])
  );

  for (genvar i = 0; i < NCells; i++) begin : g_cell
    c2p_cell #(.IDX(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vec_i  (chain[i]),
      .vec_o  (chain[i+1])
    );
  end

  c2p_post #(.STAGES(STAGES)) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vec_i       (chain[NCells]),
    .done_o      (done_o),
    .magnitude_o (magnitude_o),
    .phase_o     (phase_o)
  );

endmodule
`default_nettype wire

>>> sv/c2p_checker.sv
// Port-level checks of the converter and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module c2p_checker import c2p_pkg::*; #(
  parameter int STAGES = C2P_STAGES
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start_i,
  input wire logic               busy_o,
  input wire logic signed [15:0] real_in_i,
  input wire logic signed [15:0] imag_in_i,
  input wire logic               done_o,
  input wire logic [15:0]        magnitude_o,
  input wire logic signed [15:0] phase_o
);

  localparam int Lat = c2p_stage_count(STAGES) + 3;

  // The converter never refuses a request.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy_o raised");

  // Every result traces back to an earlier request.
  a_done_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Lat))
    else $error("result without request");

  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (magnitude_o <= C2P_MAG_MAX) &&
               (phase_o <= C2P_PHASE_MAX) && (phase_o >= -C2P_PHASE_MAX))
    else $error("result out of range");

  // A zero sample yields zero magnitude and zero phase.
  a_zero_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(real_in_i == 16'sd0 && imag_in_i == 16'sd0, Lat)
      |-> magnitude_o == 16'd0 && phase_o == 16'sd0)
    else $error("zero sample gave nonzero result");

endmodule

bind cartesian_to_polar c2p_checker #(.STAGES(STAGES)) u_c2p_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .real_in_i   (real_in_i),
  .imag_in_i   (imag_in_i),
  .done_o      (done_o),
  .magnitude_o (magnitude_o),
  .phase_o     (phase_o)
);
`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for the Cartesian-to-polar converter, with its own fixed-point model.
`timescale 1ns / 1ps
module tb;
  import c2p_pkg::*;

  localparam int       STAGES_USED = C2P_STAGES;
  localparam int       CLK_HALF    = 5;
  localparam int       PIPE_DEPTH  = STAGES_USED + 3;
  localparam int       RAND_ITEMS  = 2000;
  localparam int       QUIET_TAIL  = 300;
  localparam int       RUN_LIMIT   = 400_000;
  localparam longint   ANGLE_PI    = 64'sd52707179;
  localparam longint   MAG_CEIL    = 64'sd46341;
  localparam longint   PHASE_CEIL  = 64'sd25736;

  typedef struct {
    logic [15:0]        mag;
    logic signed [15:0] ph;
  } polar_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic signed [15:0] real_in_i = '0;
  logic signed [15:0] imag_in_i = '0;
  logic               busy_o;
  logic               done_o;
  logic [15:0]        magnitude_o;
  logic signed [15:0] phase_o;

  polar_t pending_polar[$];
  int     fail_count = 0;

  cartesian_to_polar #(
    .STAGES(STAGES_USED)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .real_in_i  (real_in_i),
    .imag_in_i  (imag_in_i),
    .done_o     (done_o),
    .magnitude_o(magnitude_o),
    .phase_o    (phase_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Vectoring rotation in 64-bit integers; >>> on a signed longint floors.
  function automatic polar_t cordic_to_polar(logic signed [15:0] re, logic signed [15:0] im);
    longint xv, yv, zv, dx, dy, mag, ph, corr;
    int     cells, gidx;
    polar_t res;
    res.mag = '0;
    res.ph  = '0;
    if (re == 0 && im == 0) return res;
    cells = STAGES_USED;
    if (cells > C2P_MAX_STAGES) cells = C2P_MAX_STAGES;
    if (cells < 1) cells = 1;
    gidx = STAGES_USED - 8;
    if (gidx < 0) gidx = 0;
    if (gidx > 16) gidx = 16;
    corr = longint'(C2P_INV_GAIN[gidx]);
    xv = longint'(re);
    yv = longint'(im);
    zv = 0;
    // Left half-plane: fold into the right half and start from plus or minus pi.
    if (xv < 0) begin
      zv = (yv >= 0) ? ANGLE_PI : -ANGLE_PI;
      xv = -xv;
      yv = -yv;
    end
    xv = xv * 256;
    yv = yv * 256;
    for (int i = 0; i < cells; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv = xv + dx;
        yv = yv - dy;
        zv = zv + longint'(C2P_ATAN[i]);
      end else begin
        xv = xv - dx;
        yv = yv + dy;
        zv = zv - longint'(C2P_ATAN[i]);
      end
    end
    if (xv < 0) xv = 0;
    mag = (xv * corr + (64'sd1 <<< 31)) >>> 32;
    if (mag > MAG_CEIL) mag = MAG_CEIL;
    ph = (zv + 1024) >>> 11;
    if (ph > PHASE_CEIL) ph = PHASE_CEIL;
    if (ph < -PHASE_CEIL) ph = -PHASE_CEIL;
    res.mag = 16'(mag);
    res.ph  = 16'(ph);
    return res;
  endfunction

  // Presents one request and holds it until the converter takes it.
  task automatic issue_sample(input logic signed [15:0] re, input logic signed [15:0] im);
    start_i   <= 1'b1;
    real_in_i <= re;
    imag_in_i <= im;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_polar.push_back(cordic_to_polar(re, im));
  endtask

  task automatic idle_gap();
    start_i <= 1'b0;
    repeat ($urandom_range(1, 13)) @(posedge clk_i);
  endtask

  task automatic test_zero_and_axes();
    issue_sample(16'sd0, 16'sd0);
    issue_sample(16'sd32767, 16'sd0);
    issue_sample(16'sd1, 16'sd0);
    issue_sample(16'sd0, 16'sd32767);
    issue_sample(16'sd0, -16'sd32768);
    issue_sample(16'sd0, -16'sd1);
    // The negative real axis must come out at plus pi.
    issue_sample(-16'sd32768, 16'sd0);
    issue_sample(-16'sd1, 16'sd0);
    idle_gap();
  endtask

  task automatic test_corners();
    issue_sample(16'sd32767, 16'sd32767);
    issue_sample(-16'sd32768, -16'sd32768);
    issue_sample(-16'sd32768, 16'sd32767);
    issue_sample(16'sd32767, -16'sd32768);
    issue_sample(16'sd1, 16'sd1);
    issue_sample(-16'sd1, -16'sd1);
    issue_sample(16'sh5555, -16'sh2AAB);
    idle_gap();
  endtask

  task automatic test_half_planes();
    // Left half-plane just above and just below the real axis picks opposite signs of pi.
    issue_sample(-16'sd20000, 16'sd1);
    issue_sample(-16'sd20000, -16'sd1);
    issue_sample(-16'sd12345, 16'sd23456);
    issue_sample(-16'sd12345, -16'sd23456);
    issue_sample(16'sd12345, 16'sd23456);
    issue_sample(16'sd12345, -16'sd23456);
    issue_sample(16'sd3, -16'sd7);
    idle_gap();
  endtask

  task automatic test_random_stream();
    logic signed [15:0] re, im, mag_pick;
    logic signed [15:0] edge_vals [6];
    bit                 gaps_on;
    edge_vals = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    gaps_on = 1'b1;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      case ($urandom_range(0, 7))
        0, 1, 2: begin
          re = 16'($urandom);
          im = 16'($urandom);
        end
        3: begin
          re = 16'($urandom_range(0, 31)) - 16'sd16;
          im = 16'($urandom_range(0, 31)) - 16'sd16;
        end
        4: begin
          re = 16'($urandom);
          im = 16'sd0;
          if ($urandom_range(0, 1)) begin
            im = re;
            re = 16'sd0;
          end
        end
        5: begin
          re = edge_vals[$urandom_range(0, 5)];
          im = edge_vals[$urandom_range(0, 5)];
        end
        6: begin
          mag_pick = 16'($urandom_range(1, 32767));
          re = $urandom_range(0, 1) ? mag_pick : -mag_pick;
          im = $urandom_range(0, 1) ? mag_pick : -mag_pick;
        end
        default: begin
          re = -16'sd1 - 16'($urandom_range(0, 32767));
          im = 16'($urandom_range(0, 4)) - 16'sd2;
        end
      endcase
      issue_sample(re, im);
      if (n % 64 == 0) gaps_on = $urandom_range(0, 1);
      if (n < RAND_ITEMS - QUIET_TAIL && gaps_on && $urandom_range(0, 3) == 0) idle_gap();
    end
    start_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : result_check
    polar_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_polar.size() == 0) begin
        $error("unexpected result: magnitude %0d phase %0d", magnitude_o, phase_o);
        fail_count++;
      end else begin
        want = pending_polar.pop_front();
        if (magnitude_o !== want.mag) begin
          $error("magnitude: expected %0d, actual %0d", want.mag, magnitude_o);
          fail_count++;
        end
        if (phase_o !== want.ph) begin
          $error("phase: expected %0d, actual %0d", want.ph, phase_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT * 2 * CLK_HALF);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_and_axes();
    test_corners();
    test_half_planes();
    test_random_stream();
    while (pending_polar.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 5) @(posedge clk_i);
    if (pending_polar.size() != 0) begin
      $error("%0d results never arrived", pending_polar.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
